// ===== rtl/core/kal_pkg.sv =====
// ----------------------------------------------------------------------------
// kal_pkg: shared types and constants of the scalar Kalman angle filter
// Operand widths of the shared multiplier, fixed-point constants of the
// filter, the reciprocal used for the gyro scaling and the clamp helper for
// the angle path.
// ----------------------------------------------------------------------------
package kal_pkg;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 32;
  localparam int PROD_W = MUL_A_W + MUL_B_W;

  localparam int DEN_W = 33;
  localparam int DELTA_W = 25;

  localparam logic [DEN_W-1:0] GYRO_DIV = 33'd33536;
  localparam logic [15:0] GYRO_HALF = 16'd16768;
  localparam logic [31:0] GYRO_RECIP = 32'd4196609267;
  localparam int GYRO_RECIP_SHIFT = 39;
  localparam logic [31:0] VAR_ONE = 32'd16777216;

  localparam logic [31:0] TIME_STEP_RST = 32'd167772;
  localparam logic [31:0] PROC_NOISE_RST = 32'd33554;
  localparam logic [31:0] MEAS_NOISE_RST = 32'd503316;

  localparam logic [1:0] REG_TIME_STEP = 2'd0;
  localparam logic [1:0] REG_PROC_NOISE = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE = 2'd2;

  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
  } clamp_t;

  function automatic clamp_t clamp_angle(input logic signed [33:0] v);
    clamp_t r;
    if (v > 34'sd2147483647) begin
      r.value = 32'sh7FFFFFFF;
      r.sat = 1'b1;
    end else if (v < -34'sd2147483648) begin
      r.value = 32'sh80000000;
      r.sat = 1'b1;
    end else begin
      r.value = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/kal_div.sv =====
// ----------------------------------------------------------------------------
// kal_div: iterative restoring divider
// Produces one quotient bit per cycle. The caller preloads the partial
// remainder with the upper numerator bits and the low bits top-aligned.
// ----------------------------------------------------------------------------
module kal_div #(
  parameter int DEN_W = 33,
  parameter int QW = 25,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DEN_W-1:0] rem_init,
  input  logic [QW-1:0]    low_init,
  input  logic [DEN_W-1:0] den,
  input  logic [CNT_W-1:0] steps,
  output logic             done,
  output logic [QW-1:0]    quo
);

  logic [DEN_W-1:0] rem;
  logic [QW-1:0]    low;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             ge;

  always_comb begin
    shifted = {rem, low[QW-1]};
    diff = {1'b0, shifted} - {2'b00, den_q};
    ge = !diff[DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= steps;
        rem <= rem_init;
        low <= low_init;
        den_q <= den;
      end else if (busy) begin
        rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        low <= {low[QW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = low;

endmodule

// ===== rtl/core/kal_mul.sv =====
// ----------------------------------------------------------------------------
// kal_mul: shared unsigned multiplier
// One registered product per cycle while en is high; the sequencer steers the operands.
// ----------------------------------------------------------------------------
module kal_mul import kal_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

// ===== rtl/core/scalar_kalman_angle_filter_unit.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_angle_filter_unit: one-axis Kalman filter, gyro and accel
// An update request steps through S_PMUL, S_DMUL, S_GAIN, S_GWAIT for the
// serial gain divide (skipped when the sum s_reg is zero), S_CMUL, S_CORR and
// S_VAR to S_DONE; an init request goes straight to S_DONE. A new request is
// taken in S_IDLE, to which S_DONE returns once the output register is free.
// Synchronous reset restores the register defaults, zero angle and unit variance.
// ----------------------------------------------------------------------------
module scalar_kalman_angle_filter_unit import kal_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic signed [31:0] acc_angle,
  input  logic signed [15:0] gyro_raw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] angle_out,
  output logic               saturated,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int G = GAIN_FRAC_BITS;
  localparam int KW = G + 1;
  localparam int NUM_W = G + 33;
  localparam int CNT_W = $clog2(KW + 1);
  localparam logic [KW-1:0] ONE_GAIN = {1'b1, {G{1'b0}}};
  localparam logic [PROD_W-1:0] HALF_GAIN = PROD_W'(1) << (G - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PMUL = 4'd1;
  localparam logic [3:0] S_DMUL = 4'd2;
  localparam logic [3:0] S_GAIN = 4'd3;
  localparam logic [3:0] S_GWAIT = 4'd4;
  localparam logic [3:0] S_CMUL = 4'd5;
  localparam logic [3:0] S_CORR = 4'd6;
  localparam logic [3:0] S_VAR = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]         state;
  logic [23:0]        time_step;
  logic [31:0]        process_noise;
  logic [31:0]        measurement_noise;
  logic signed [31:0] angle_est;
  logic [31:0]        var_est;

  logic signed [31:0] acc_q;
  logic signed [15:0] gyro_q;
  logic [31:0]        p_reg;
  logic [32:0]        s_reg;
  logic signed [31:0] ang_reg;
  logic [KW-1:0]      gain;
  logic               err_neg;
  logic               sat_acc;

  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  logic               div_start;
  logic [DEN_W-1:0]   div_rem_init;
  logic [KW-1:0]      div_low_init;
  logic [DEN_W-1:0]   div_den;
  logic [CNT_W-1:0]   div_steps;
  logic               div_done;
  logic [KW-1:0]      div_quo;

  logic [32:0]        p_sum;
  logic [31:0]        p_val;
  logic [32:0]        s_sum;
  logic               gyro_neg;
  logic [15:0]        gyro_mag;
  logic [39:0]        dnum;
  logic [NUM_W-1:0]   gnum;
  logic [DELTA_W-1:0] dq;
  logic signed [25:0] delta_s;
  logic signed [33:0] ang_sum;
  clamp_t             pred;
  logic signed [32:0] err;
  logic [32:0]        err_mag;
  logic [PROD_W-1:0]  rnd;
  logic [32:0]        corr_mag;
  logic signed [33:0] corr_s;
  logic signed [33:0] fin_sum;
  clamp_t             fin;

  always_comb begin
    p_sum = {1'b0, var_est} + {1'b0, process_noise};
    p_val = p_sum[32] ? 32'hFFFFFFFF : p_sum[31:0];
    s_sum = {1'b0, p_reg} + {1'b0, measurement_noise};
    gyro_neg = gyro_q[15];
    gyro_mag = gyro_neg ? (~gyro_q + 16'd1) : gyro_q;
    dnum = prod[39:0] + 40'(GYRO_HALF);
    gnum = (NUM_W'(p_reg) << G) + NUM_W'(s_reg[32:1]);
    dq = prod[GYRO_RECIP_SHIFT +: DELTA_W];
    delta_s = gyro_neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
    ang_sum = 34'(angle_est) + 34'(delta_s);
    pred = clamp_angle(ang_sum);
    err = 33'(acc_q) - 33'(ang_reg);
    err_mag = err[32] ? 33'(-err) : 33'(err);
    rnd = prod + HALF_GAIN;
    corr_mag = rnd[G+32:G];
    corr_s = err_neg ? -$signed({1'b0, corr_mag}) : $signed({1'b0, corr_mag});
    fin_sum = 34'(ang_reg) + corr_s;
    fin = clamp_angle(fin_sum);
  end

  always_comb begin
    mul_en = 1'b0;
    mul_a = MUL_A_W'(gyro_mag);
    mul_b = MUL_B_W'(time_step);
    case (state)
      S_PMUL: begin
        mul_en = 1'b1;
      end
      S_DMUL: begin
        mul_en = 1'b1;
        mul_a = MUL_A_W'(dnum[39:8]);
        mul_b = GYRO_RECIP;
      end
      S_CMUL: begin
        mul_en = 1'b1;
        mul_a = err_mag;
        mul_b = MUL_B_W'(gain);
      end
      S_CORR: begin
        mul_en = 1'b1;
        mul_a = MUL_A_W'(ONE_GAIN - gain);
        mul_b = p_reg;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    div_start = (state == S_GAIN) && (s_reg != 33'd0);
    div_rem_init = DEN_W'(gnum >> KW);
    div_low_init = gnum[KW-1:0];
    div_den = s_reg;
    div_steps = CNT_W'(KW);
  end

  kal_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  kal_div #(
    .DEN_W (DEN_W),
    .QW    (KW),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem_init),
    .low_init (div_low_init),
    .den      (div_den),
    .steps    (div_steps),
    .done     (div_done),
    .quo      (div_quo)
  );

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      time_step <= TIME_STEP_RST[23:0];
      process_noise <= PROC_NOISE_RST;
      measurement_noise <= MEAS_NOISE_RST;
      angle_est <= '0;
      var_est <= VAR_ONE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIME_STEP: time_step <= cfg_data[23:0];
          REG_PROC_NOISE: process_noise <= cfg_data;
          REG_MEAS_NOISE: measurement_noise <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            acc_q <= acc_angle;
            gyro_q <= gyro_raw;
            sat_acc <= 1'b0;
            if (req_type) begin
              angle_est <= acc_angle;
              var_est <= VAR_ONE;
              state <= S_DONE;
            end else begin
              state <= S_PMUL;
            end
          end
        end
        S_PMUL: begin
          p_reg <= p_val;
          sat_acc <= p_sum[32];
          state <= S_DMUL;
        end
        S_DMUL: begin
          s_reg <= s_sum;
          state <= S_GAIN;
        end
        S_GAIN: begin
          ang_reg <= pred.value;
          sat_acc <= sat_acc | pred.sat;
          if (s_reg == 33'd0) begin
            gain <= ONE_GAIN;
            state <= S_CMUL;
          end else begin
            state <= S_GWAIT;
          end
        end
        S_GWAIT: begin
          if (div_done) begin
            gain <= div_quo;
            state <= S_CMUL;
          end
        end
        S_CMUL: begin
          err_neg <= err[32];
          state <= S_CORR;
        end
        S_CORR: begin
          angle_est <= fin.value;
          state <= S_VAR;
        end
        S_VAR: begin
          var_est <= rnd[G+31:G];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            angle_out <= angle_est;
            saturated <= sat_acc;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_GWAIT))
    else $error("Divider finished outside the gain wait state.");

  a_init_loads_unit_var: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && req_type) |=> (state == S_DONE && var_est == VAR_ONE))
    else $error("Init request did not load the unit variance.");

  a_gain_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMUL) |-> (gain <= ONE_GAIN))
    else $error("Kalman gain exceeds one.");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE))
    else $error("Result overwritten while the previous one is pending.");
`endif

endmodule
